// ----- rtl/core/cst_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the client slot table
package cst_pkg;

    localparam int OPCODE_W = 2;
    localparam int ADDR_W   = 48;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int IDX_W    = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } state_t;

    typedef struct packed {
        logic              valid;
        opcode_t           op;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] rd_idx;
        logic              match_hit;
        logic [IDX_W-1:0]  match_slot;
        logic              free_hit;
        logic [IDX_W-1:0]  free_slot;
        logic              rd_conn;
        logic [ADDR_W-1:0] rd_addr;
    } token_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  slot;
        logic              conn;
        logic [ADDR_W-1:0] addr;
    } wr_t;

endpackage

// ----- rtl/core/cst_req_if.sv -----
`timescale 1ns / 1ps
// request channel: operation word into the slot table
interface cst_req_if;
    logic                         valid;
    logic                         ready;
    logic [cst_pkg::OPCODE_W-1:0] opcode;
    logic [cst_pkg::ADDR_W-1:0]   client_address;
    logic [cst_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, opcode, client_address, slot_index, input ready);
    modport sink (input valid, opcode, client_address, slot_index, output ready);
endinterface

// ----- rtl/core/cst_rsp_if.sv -----
`timescale 1ns / 1ps
// response channel: result word out of the slot table
interface cst_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cst_pkg::SLOT_W-1:0]   slot_number;
    logic [cst_pkg::STATUS_W-1:0] status;
    logic                         slot_connected;
    logic [cst_pkg::ADDR_W-1:0]   slot_address;
    logic [cst_pkg::COUNT_W-1:0]  connected_count;

    modport source (output valid, slot_number, status, slot_connected, slot_address,
                    connected_count, input ready);
    modport sink (input valid, slot_number, status, slot_connected, slot_address,
                  connected_count, output ready);
endinterface

// ----- rtl/core/cst_cell.sv -----
`timescale 1ns / 1ps
// one slot of the table: stores flag and address, inspects the passing search token
module cst_cell #(
    parameter int INDEX = 0,
    parameter int AW    = 48
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cst_pkg::token_t tok_in,
    input  cst_pkg::wr_t    wr,
    output cst_pkg::token_t tok_out
);
    import cst_pkg::*;

    logic             conn_reg, conn_next;
    logic [AW-1:0]    addr_reg, addr_next;
    token_t           tok_reg, tok_next;
    logic [IDX_W-1:0] my_idx;
    logic             hit;

    assign my_idx = IDX_W'(INDEX);
    assign hit    = conn_reg && (addr_reg == tok_in.addr[AW-1:0]);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid)
        begin
            // lowest index wins since the token visits slots in order
            if (hit && !tok_in.match_hit)
            begin
                tok_next.match_hit  = 1'b1;
                tok_next.match_slot = my_idx;
            end
            if (!conn_reg && !tok_in.free_hit)
            begin
                tok_next.free_hit  = 1'b1;
                tok_next.free_slot = my_idx;
            end
            if ((tok_in.op == OP_READ) && (IDX_W'(tok_in.rd_idx) == my_idx))
            begin
                tok_next.rd_conn = conn_reg;
                tok_next.rd_addr = ADDR_W'(addr_reg);
            end
        end
    end

    always_comb
    begin
        conn_next = conn_reg;
        addr_next = addr_reg;
        if (wr.en && (wr.slot == my_idx))
        begin
            conn_next = wr.conn;
            addr_next = wr.addr[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_reg <= 1'b0;
            addr_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            conn_reg <= conn_next;
            addr_reg <= addr_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/core/cst_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer: launches the search token, resolves the result, writes back and counts
module cst_ctrl #(
    parameter int SLOTS = 64,
    parameter int AW    = 48
) (
    input  logic            clk,
    input  logic            rst_n,
    cst_req_if.sink         request,
    cst_rsp_if.source       response,
    input  cst_pkg::token_t tok_done,
    output cst_pkg::token_t tok_launch,
    output cst_pkg::wr_t    wr
);
    import cst_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                conn_reg, conn_next;
    logic [ADDR_W-1:0]   saddr_reg, saddr_next;
    logic                load_out;
    logic                in_ready;
    logic                accept;
    logic [ADDR_W-1:0]   addr_mask;
    logic [CW+6:0]       count_ext;

    assign addr_mask = ADDR_W'({AW{1'b1}});
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || response.ready);
    assign accept    = request.valid && in_ready;
    assign request.ready = in_ready;

    always_comb
    begin
        tok_launch        = '0;
        tok_launch.valid  = accept;
        tok_launch.op     = opcode_t'(request.opcode);
        tok_launch.addr   = request.client_address & addr_mask;
        tok_launch.rd_idx = request.slot_index;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;
        slot_next      = '0;
        status_next    = ST_DONE;
        conn_next      = 1'b0;
        saddr_next     = '0;
        wr             = '0;
        if (out_valid_reg && response.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_BUSY;
            end
            S_BUSY:
            begin
                if (tok_done.valid)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    load_out       = 1'b1;
                    case (tok_done.op)
                        OP_ADD:
                        begin
                            if (tok_done.match_hit)
                            begin
                                status_next = ST_PRESENT;
                                slot_next   = SLOT_W'(tok_done.match_slot);
                            end
                            else if (tok_done.free_hit)
                            begin
                                slot_next  = SLOT_W'(tok_done.free_slot);
                                wr.en      = 1'b1;
                                wr.slot    = tok_done.free_slot;
                                wr.conn    = 1'b1;
                                wr.addr    = tok_done.addr;
                                count_next = count_reg + CW'(1);
                            end
                            else
                                status_next = ST_FULL;
                        end
                        OP_REMOVE:
                        begin
                            if (tok_done.match_hit)
                            begin
                                slot_next = SLOT_W'(tok_done.match_slot);
                                wr.en     = 1'b1;
                                wr.slot   = tok_done.match_slot;
                                if (count_reg != '0)
                                    count_next = count_reg - CW'(1);
                            end
                            else
                                status_next = ST_MISSING;
                        end
                        OP_FIND:
                        begin
                            if (tok_done.match_hit)
                                slot_next = SLOT_W'(tok_done.match_slot);
                            else
                                status_next = ST_MISSING;
                        end
                        OP_READ:
                        begin
                            slot_next  = tok_done.rd_idx;
                            conn_next  = tok_done.rd_conn;
                            saddr_next = tok_done.rd_addr;
                        end
                        default:
                            status_next = ST_DONE;
                    endcase
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            slot_reg   <= slot_next;
            status_reg <= status_next;
            conn_reg   <= conn_next;
            saddr_reg  <= saddr_next;
        end
    end

    assign count_ext = {7'b0, count_reg};

    assign response.valid           = out_valid_reg;
    assign response.slot_number     = slot_reg;
    assign response.status          = status_reg;
    assign response.slot_connected  = conn_reg;
    assign response.slot_address    = saddr_reg;
    assign response.connected_count = count_ext[COUNT_W-1:0];

endmodule

// ----- rtl/core/client_slot_table.sv -----
`timescale 1ns / 1ps
// client slot table: chain of slot cells searched by a token that walks the cells in order
// the token passes the register of each cell in turn, and the response word is
// registered in the sequencer; the table holds one search at a time
// a new request is taken in the cycle the previous response is taken
// reset clears every slot and the connected count at once, no clearing pass
module client_slot_table #(
    parameter int SLOTS        = 64,
    parameter int ADDRESS_BITS = 48
) (
    input  logic      clk,
    input  logic      rst_n,
    cst_req_if.sink   request,
    cst_rsp_if.source response
);
    import cst_pkg::*;

    localparam int AW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;

    token_t chain [SLOTS+1];
    wr_t    wr;

    cst_ctrl #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .response   (response),
        .tok_done   (chain[SLOTS]),
        .tok_launch (chain[0]),
        .wr         (wr)
    );

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        cst_cell #(
            .INDEX (i),
            .AW    (AW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .wr      (wr),
            .tok_out (chain[i+1])
        );
    end

endmodule

// ----- rtl/core/cst_checker.sv -----
`timescale 1ns / 1ps
// port-level checks on the client slot table, bound to the top level
module cst_checker #(
    parameter int SLOTS = 64
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cst_pkg::SLOT_W-1:0]   slot_number,
    input logic [cst_pkg::STATUS_W-1:0] status,
    input logic [cst_pkg::COUNT_W-1:0]  connected_count
);
    import cst_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response word dropped before it was taken");

    a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while a response word is stuck");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while a search is running");

    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL || status == ST_MISSING) |-> slot_number == '0)
        else $error("failed operation reports a nonzero slot");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(connected_count) <= SLOTS)
        else $error("connected count above table size");

endmodule

bind client_slot_table cst_checker #(.SLOTS(SLOTS)) u_cst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (request.valid),
    .in_ready        (request.ready),
    .out_valid       (response.valid),
    .out_ready       (response.ready),
    .slot_number     (response.slot_number),
    .status          (response.status),
    .connected_count (response.connected_count)
);
